FILE: src/brf_pkg.sv
// Shared widths, operation codes and command types for the byte ring buffer.
package brf_pkg;

  // Fixed field widths of the request and result transfers.
  localparam int OP_W        = 3;
  localparam int LEN_W       = 4;
  localparam int BYTE_W      = 8;
  localparam int MAX_LANES   = 8;
  localparam int DATA_W      = MAX_LANES * BYTE_W;
  localparam int SPACE_W     = 10;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 88;

  // Default configuration of the top level.
  localparam int DEPTH_DEF = 1024;
  localparam int LANES_DEF = 8;

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 3'd0,
    OP_BEGIN  = 3'd1,
    OP_AMEND  = 3'd2,
    OP_COMMIT = 3'd3,
    OP_READ   = 3'd4,
    OP_PEEK   = 3'd5,
    OP_SKIP   = 3'd6,
    OP_RESET  = 3'd7
  } op_e;

  // Memory command broadcast to every byte lane.
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [LEN_W-1:0] len;
  } mem_cmd_t;

endpackage

FILE: src/brf_lane.sv
// One byte lane: address and enable of byte LANE within a request.
module brf_lane import brf_pkg::*; #(
  parameter int IDX_W = 10,
  parameter int LANE  = 0
) (
  input  mem_cmd_t         cmd_i,
  input  logic [IDX_W-1:0] base_i,
  output logic             en_o,
  output logic [IDX_W-1:0] addr_o
);

  // The lane takes part only when its byte lies inside the requested length.
  assign en_o   = (cmd_i.wr || cmd_i.rd) && (LEN_W'(LANE) < cmd_i.len);
  // The address wraps naturally at the power-of-two depth.
  assign addr_o = base_i + IDX_W'(LANE);

endmodule

FILE: src/brf_bank.sv
// One byte-wide memory bank with a registered read port.
module brf_bank import brf_pkg::*; #(
  parameter int ROWS  = 128,
  parameter int ROW_W = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [BYTE_W-1:0] wdata_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [ROWS];
  logic [BYTE_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[row_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[row_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/brf_merge.sv
// Rotates bank read data back into request byte order and masks unused bytes.
module brf_merge import brf_pkg::*; #(
  parameter int LANES  = 8,
  parameter int BANKS  = 8,
  parameter int BANK_W = 3
) (
  input  logic [BANKS-1:0][BYTE_W-1:0] bank_rdata_i,
  input  logic [BANK_W-1:0]            base_bank_i,
  input  logic [LEN_W-1:0]             count_i,
  input  logic                         rd_i,
  output logic [DATA_W-1:0]            read_data_o
);

  // Byte i of the result comes from the bank that held address base + i.
  always_comb begin
    read_data_o = '0;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (rd_i && (i < LANES) && (LEN_W'(i) < count_i)) begin
        read_data_o[i*BYTE_W +: BYTE_W] =
          bank_rdata_i[base_bank_i + BANK_W'(i)];
      end
    end
  end

endmodule

FILE: src/byte_ring_fifo_transactional.sv
// Top level of the transactional circular byte buffer.
//
//  Channel  Direction  tdata (low bit up)                                 tuser
//  s_axis   in         length[3:0], write_data[67:4], zero[71:68]         operation[2:0]
//  m_axis   out        byte_count[3:0], read_data[67:4],                  accepted[0]
//                      readable_space[77:68], free_space[87:78]
//
// One request is taken per cycle while results keep draining. Request fields
// and bank read data are registered when the request transfers (the registered
// read port of the byte banks sets that extra stage); the result then loads into
// the output register once it is free. Reset clears the four indices and all
// handshake state; the bank contents are left as they are. A result that waits
// at the output stalls the input only once a second request is in flight.
module byte_ring_fifo_transactional import brf_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int LANES = LANES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // length, write_data, zero pad
  input  logic [OP_W-1:0]        s_axis_tuser,  // operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // byte_count, read_data,
                                                // readable_space, free_space
  output logic [0:0]             m_axis_tuser   // accepted
);

  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CMP_W     = (IDX_W > LEN_W) ? IDX_W : LEN_W;
  localparam int BANKS_RAW = (LANES > 2) ? (2 ** $clog2(LANES)) : 2;
  localparam int BANKS     = (BANKS_RAW > DEPTH) ? DEPTH : BANKS_RAW;
  localparam int BANK_W    = $clog2(BANKS);
  localparam int ROWS      = DEPTH / BANKS;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Request fields.
  op_e               op;
  logic [LEN_W-1:0]  len;
  logic [DATA_W-1:0] wdata;

  assign op    = op_e'(s_axis_tuser);
  assign len   = s_axis_tdata[LEN_W-1:0];
  assign wdata = s_axis_tdata[LEN_W +: DATA_W];

  // Indices.
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] stg_idx_q, stg_idx_d;
  logic [IDX_W-1:0] snap_idx_q, snap_idx_d;

  // Handshake and pipeline control.
  logic in_fire;
  logic load;
  logic busy_q;
  logic out_valid_q;

  assign load          = busy_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !busy_q || load;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Request decode and space checks.
  logic [IDX_W-1:0] rs_cur, fs_cur, fs_stg, rs_nxt, fs_nxt;
  logic             fits;
  logic             ok;
  logic [LEN_W-1:0] cnt;
  logic             do_wr, do_rd;
  logic [IDX_W-1:0] base;

  assign rs_cur = wr_idx_q - rd_idx_q;
  assign fs_cur = rd_idx_q - wr_idx_q - IDX_W'(1);
  assign fs_stg = snap_idx_q - stg_idx_q - IDX_W'(1);
  assign fits   = (len <= LEN_W'(LANES));

  always_comb begin
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    stg_idx_d  = stg_idx_q;
    snap_idx_d = snap_idx_q;
    ok         = 1'b0;
    cnt        = '0;
    do_wr      = 1'b0;
    do_rd      = 1'b0;
    base       = wr_idx_q;
    unique case (op) inside
      OP_WRITE: begin
        if (fits && (CMP_W'(fs_cur) >= CMP_W'(len))) begin
          wr_idx_d = wr_idx_q + IDX_W'(len);
          ok       = 1'b1;
          cnt      = len;
          do_wr    = 1'b1;
        end
      end
      OP_BEGIN: begin
        snap_idx_d = rd_idx_q;
        stg_idx_d  = wr_idx_q;
        ok         = 1'b1;
      end
      OP_AMEND: begin
        base = stg_idx_q;
        if (fits && (CMP_W'(fs_stg) >= CMP_W'(len))) begin
          stg_idx_d = stg_idx_q + IDX_W'(len);
          ok        = 1'b1;
          cnt       = len;
          do_wr     = 1'b1;
        end
      end
      OP_COMMIT: begin
        wr_idx_d = stg_idx_q;
        ok       = 1'b1;
      end
      OP_READ, OP_PEEK: begin
        base = rd_idx_q;
        if (fits && (CMP_W'(rs_cur) >= CMP_W'(len))) begin
          if (op == OP_READ) begin
            rd_idx_d = rd_idx_q + IDX_W'(len);
          end
          ok    = 1'b1;
          cnt   = len;
          do_rd = 1'b1;
        end
      end
      OP_SKIP: begin
        if (fits && (CMP_W'(rs_cur) >= CMP_W'(len))) begin
          rd_idx_d = rd_idx_q + IDX_W'(len);
          ok       = 1'b1;
          cnt      = len;
        end
      end
      OP_RESET: begin
        wr_idx_d   = '0;
        rd_idx_d   = '0;
        stg_idx_d  = '0;
        snap_idx_d = '0;
        ok         = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign rs_nxt = wr_idx_d - rd_idx_d;
  assign fs_nxt = rd_idx_d - wr_idx_d - IDX_W'(1);

  // Memory command, active only for the request being transferred.
  mem_cmd_t cmd;

  assign cmd.wr  = in_fire && do_wr;
  assign cmd.rd  = in_fire && do_rd;
  assign cmd.len = cnt;

  // Byte lanes.
  logic [LANES-1:0]            lane_en;
  logic [LANES-1:0][IDX_W-1:0] lane_addr;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    brf_lane #(
      .IDX_W (IDX_W),
      .LANE  (l)
    ) u_lane (
      .cmd_i  (cmd),
      .base_i (base),
      .en_o   (lane_en[l]),
      .addr_o (lane_addr[l])
    );
  end

  // Route each lane to the bank that its address selects.
  logic [BANKS-1:0]             bank_we;
  logic [BANKS-1:0]             bank_re;
  logic [BANKS-1:0][ROW_W-1:0]  bank_row;
  logic [BANKS-1:0][BYTE_W-1:0] bank_wdata;
  logic [BANKS-1:0][BYTE_W-1:0] bank_rdata;

  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      bank_we[b]    = 1'b0;
      bank_re[b]    = 1'b0;
      bank_row[b]   = '0;
      bank_wdata[b] = '0;
      for (int l = 0; l < LANES; l++) begin
        if (lane_en[l] && (lane_addr[l][BANK_W-1:0] == BANK_W'(b))) begin
          bank_we[b]    = cmd.wr;
          bank_re[b]    = cmd.rd;
          bank_row[b]   = ROW_W'(lane_addr[l] >> BANK_W);
          bank_wdata[b] = wdata[l*BYTE_W +: BYTE_W];
        end
      end
    end
  end

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    brf_bank #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .re_i    (bank_re[b]),
      .row_i   (bank_row[b]),
      .wdata_i (bank_wdata[b]),
      .rdata_o (bank_rdata[b])
    );
  end

  // Index and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      stg_idx_q   <= '0;
      snap_idx_q  <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        wr_idx_q   <= wr_idx_d;
        rd_idx_q   <= rd_idx_d;
        stg_idx_q  <= stg_idx_d;
        snap_idx_q <= snap_idx_d;
      end
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result fields of the request in flight, waiting for bank read data.
  logic               ok_q;
  logic [LEN_W-1:0]   cnt_q;
  logic               rd_q;
  logic [BANK_W-1:0]  bank_q;
  logic [SPACE_W-1:0] rs_q;
  logic [SPACE_W-1:0] fs_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ok_q   <= ok;
      cnt_q  <= cnt;
      rd_q   <= do_rd;
      bank_q <= base[BANK_W-1:0];
      rs_q   <= SPACE_W'(rs_nxt);
      fs_q   <= SPACE_W'(fs_nxt);
    end
  end

  // Merge the bank read data into request byte order.
  logic [DATA_W-1:0] read_data;

  brf_merge #(
    .LANES  (LANES),
    .BANKS  (BANKS),
    .BANK_W (BANK_W)
  ) u_merge (
    .bank_rdata_i (bank_rdata),
    .base_bank_i  (bank_q),
    .count_i      (cnt_q),
    .rd_i         (rd_q),
    .read_data_o  (read_data)
  );

  // Output register.
  logic               m_ok_q;
  logic [LEN_W-1:0]   m_cnt_q;
  logic [DATA_W-1:0]  m_data_q;
  logic [SPACE_W-1:0] m_rs_q;
  logic [SPACE_W-1:0] m_fs_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_ok_q   <= ok_q;
      m_cnt_q  <= cnt_q;
      m_data_q <= read_data;
      m_rs_q   <= rs_q;
      m_fs_q   <= fs_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {m_fs_q, m_rs_q, m_data_q, m_cnt_q};
  assign m_axis_tuser  = m_ok_q;

endmodule

FILE: src/brf_checker.sv
// Port-level checks of the byte ring buffer, bound to the top level.
module brf_checker import brf_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int LANES = LANES_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,  // byte_count, read_data,
                                               // readable_space, free_space
  input logic [0:0]             m_axis_tuser   // accepted
);

  localparam logic [SPACE_W:0] SUM_MASK = (SPACE_W+1)'((DEPTH - 1) % (2 ** SPACE_W));

  logic [LEN_W-1:0]   cnt;
  logic [DATA_W-1:0]  rdata;
  logic [SPACE_W-1:0] rs;
  logic [SPACE_W-1:0] fs;
  logic [SPACE_W:0]   space_sum;

  assign cnt       = m_axis_tdata[LEN_W-1:0];
  assign rdata     = m_axis_tdata[LEN_W +: DATA_W];
  assign rs        = m_axis_tdata[LEN_W+DATA_W +: SPACE_W];
  assign fs        = m_axis_tdata[LEN_W+DATA_W+SPACE_W +: SPACE_W];
  assign space_sum = {1'b0, rs} + {1'b0, fs} + (SPACE_W+1)'(1);

  // Readable and free space always add up to one less than the depth.
  a_space_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((space_sum & SUM_MASK) == '0))
    else $error("readable and free space do not add up to the depth less one");

  // A refused request moves no bytes and returns no data.
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> ((cnt == '0) && (rdata == '0)))
    else $error("refused request reports bytes or data");

  // No result moves more bytes than there are lanes.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cnt <= LEN_W'(LANES)))
    else $error("byte count exceeds the lane count");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind byte_ring_fifo_transactional brf_checker #(
  .DEPTH (DEPTH),
  .LANES (LANES)
) u_brf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/tb.sv
// Self-checking testbench for the transactional circular byte buffer.
`timescale 1ns / 100ps

module tb;
  import brf_pkg::*;

  // One request item and one result item as the testbench sees them.
  typedef struct packed {
    op_e              op;
    logic [LEN_W-1:0] len;
    logic [63:0]      data;
  } ring_req_t;

  typedef struct packed {
    logic                ok;
    logic [LEN_W-1:0]    cnt;
    logic [63:0]         rdata;
    logic [SPACE_W-1:0]  avail;
    logic [SPACE_W-1:0]  room;
  } ring_result_t;

  localparam int RING_DEPTH = DEPTH_DEF;
  localparam int RING_LANES = LANES_DEF;
  localparam int REQ_TARGET = 1150;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]        s_axis_tuser  = OP_WRITE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  byte_ring_fifo_transactional #(
    .DEPTH(RING_DEPTH),
    .LANES(RING_LANES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // length, write_data, zero pad
    .s_axis_tuser  (s_axis_tuser),   // operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // byte_count, read_data, readable_space, free_space
    .m_axis_tuser  (m_axis_tuser)    // accepted
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the byte store and the four ring indices.
  logic [7:0]         ring_mem [RING_DEPTH];
  logic [SPACE_W-1:0] wr_ptr   = '0;
  logic [SPACE_W-1:0] rd_ptr   = '0;
  logic [SPACE_W-1:0] stg_ptr  = '0;
  logic [SPACE_W-1:0] snap_ptr = '0;

  ring_req_t    req_q[$];
  ring_result_t ring_expect_q[$];

  int total_reqs     = 0;
  int taken_count    = 0;
  int result_count   = 0;
  int short_count    = 0;
  int full_seen      = 0;
  int mismatch_count = 0;

  // Driver and receiver pacing state.
  logic      req_taken  = 1'b0;
  int        burst_left = 4;
  int        gap_left   = 0;
  int        sink_mode  = 0;
  int        sink_timer = 0;
  logic [7:0] stall_pat = 8'hA5;
  ring_req_t next_req;

  function automatic logic [SPACE_W-1:0] ring_used(logic [SPACE_W-1:0] rp,
                                                   logic [SPACE_W-1:0] wp);
    return wp - rp;
  endfunction

  function automatic logic [SPACE_W-1:0] ring_free(logic [SPACE_W-1:0] rp,
                                                   logic [SPACE_W-1:0] wp);
    return rp - wp - 10'd1;
  endfunction

  // Apply one request to the predictor state and return the expected result.
  function automatic ring_result_t ring_apply(ring_req_t rq);
    ring_result_t       res;
    logic [SPACE_W-1:0] addr;
    logic               fits;
    int                 i;
    res  = '0;
    fits = (rq.len <= RING_LANES);
    case (rq.op)
      OP_WRITE: begin
        if (fits && ring_free(rd_ptr, wr_ptr) >= rq.len) begin
          for (i = 0; i < rq.len; i++) begin
            addr = wr_ptr + 10'(i);
            ring_mem[addr] = rq.data[8*i +: 8];
          end
          wr_ptr  = wr_ptr + 10'(rq.len);
          res.ok  = 1'b1;
          res.cnt = rq.len;
        end
      end
      OP_BEGIN: begin
        snap_ptr = rd_ptr;
        stg_ptr  = wr_ptr;
        res.ok   = 1'b1;
      end
      OP_AMEND: begin
        if (fits && ring_free(snap_ptr, stg_ptr) >= rq.len) begin
          for (i = 0; i < rq.len; i++) begin
            addr = stg_ptr + 10'(i);
            ring_mem[addr] = rq.data[8*i +: 8];
          end
          stg_ptr = stg_ptr + 10'(rq.len);
          res.ok  = 1'b1;
          res.cnt = rq.len;
        end
      end
      OP_COMMIT: begin
        wr_ptr = stg_ptr;
        res.ok = 1'b1;
      end
      OP_READ, OP_PEEK, OP_SKIP: begin
        if (fits && ring_used(rd_ptr, wr_ptr) >= rq.len) begin
          if (rq.op != OP_SKIP) begin
            for (i = 0; i < rq.len; i++) begin
              addr = rd_ptr + 10'(i);
              res.rdata[8*i +: 8] = ring_mem[addr];
            end
          end
          if (rq.op != OP_PEEK) rd_ptr = rd_ptr + 10'(rq.len);
          res.ok  = 1'b1;
          res.cnt = rq.len;
        end
      end
      default: begin
        wr_ptr   = '0;
        rd_ptr   = '0;
        stg_ptr  = '0;
        snap_ptr = '0;
        res.ok   = 1'b1;
      end
    endcase
    res.avail = ring_used(rd_ptr, wr_ptr);
    res.room  = ring_free(rd_ptr, wr_ptr);
    return res;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic void add_req(op_e op, int len, logic [63:0] data);
    ring_req_t rq;
    rq.op   = op;
    rq.len  = LEN_W'(len);
    rq.data = data;
    req_q.push_back(rq);
  endfunction

  // Mostly legal lengths, now and then one above the lane count.
  function automatic int rnd_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(RING_LANES + 1, 15);
    return $urandom_range(0, RING_LANES);
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Driver: present the next pending request at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || req_taken) begin
        if (gap_left > 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left      <= gap_left - 1;
        end else if (req_q.size() > 0) begin
          next_req      = req_q.pop_front();
          s_axis_tdata  <= {4'b0, next_req.data, next_req.len};
          s_axis_tuser  <= next_req.op;
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end

      // Receiver: switch between stall styles whenever the mode timer runs out.
      if (sink_timer == 0) begin
        sink_mode  <= $urandom_range(0, 3);
        sink_timer <= $urandom_range(20, 80);
        stall_pat  <= 8'($urandom);
      end else begin
        sink_timer <= sink_timer - 1;
        stall_pat  <= {stall_pat[6:0], stall_pat[7]};
      end
      case (sink_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= stall_pat[0];
      endcase
    end
  end

  // Monitor: predict on each request transfer, check each result transfer.
  always @(posedge clk_i) begin
    ring_req_t    rq;
    ring_result_t exp_r;
    if (rst_ni) begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        rq.op   = op_e'(s_axis_tuser);
        rq.len  = s_axis_tdata[3:0];
        rq.data = s_axis_tdata[67:4];
        exp_r   = ring_apply(rq);
        ring_expect_q.push_back(exp_r);
        taken_count++;
        if (!exp_r.ok) short_count++;
        if (exp_r.room == 0) full_seen++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (ring_expect_q.size() == 0) begin
          $error("result transfer arrived with no pending expectation");
          mismatch_count++;
        end else begin
          exp_r = ring_expect_q.pop_front();
          check_field("accepted", 64'(exp_r.ok), 64'(m_axis_tuser[0]));
          check_field("byte_count", 64'(exp_r.cnt), 64'(m_axis_tdata[3:0]));
          check_field("read_data", exp_r.rdata, m_axis_tdata[67:4]);
          check_field("readable_space", 64'(exp_r.avail), 64'(m_axis_tdata[77:68]));
          check_field("free_space", 64'(exp_r.room), 64'(m_axis_tdata[87:78]));
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int seg;
    int n;
    int k;

    // Directed requests: field extremes and the corner cases.
    add_req(OP_READ, 0, rnd64());                  // zero length on empty ring
    add_req(OP_READ, 1, rnd64());                  // short readable space
    add_req(OP_WRITE, 9, rnd64());                 // above the lane count
    add_req(OP_WRITE, 8, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(OP_PEEK, 8, rnd64());
    add_req(OP_PEEK, 0, rnd64());
    add_req(OP_READ, 9, rnd64());
    add_req(OP_WRITE, 0, rnd64());
    add_req(OP_WRITE, 8, 64'h0);
    add_req(OP_READ, 8, rnd64());
    add_req(OP_SKIP, 9, rnd64());
    add_req(OP_SKIP, 8, rnd64());
    add_req(OP_SKIP, 1, rnd64());                  // empty ring
    add_req(OP_BEGIN, 0, rnd64());
    add_req(OP_AMEND, 8, rnd64());
    add_req(OP_WRITE, 3, rnd64());                 // plain write inside a staged write
    add_req(OP_READ, 4, rnd64());                  // only three bytes readable
    add_req(OP_AMEND, 15, rnd64());
    add_req(OP_COMMIT, 0, rnd64());
    add_req(OP_READ, 8, rnd64());
    add_req(OP_RESET, 0, rnd64());
    add_req(OP_COMMIT, 0, rnd64());                // commit with no open staged write
    add_req(OP_READ, 1, rnd64());

    // One lap around the ring so that every entry holds written data.
    for (k = 0; k < RING_DEPTH / RING_LANES; k++) begin
      add_req(OP_WRITE, RING_LANES, rnd64());
      add_req(OP_READ, RING_LANES, rnd64());
    end

    // Random segments, mostly well-formed, some noise.
    while (req_q.size() < REQ_TARGET) begin
      seg = $urandom_range(0, 9);
      case (seg)
        0, 1, 2: begin
          n = $urandom_range(5, 25);
          for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
              0:       add_req(OP_WRITE, rnd_len(), rnd64());
              1:       add_req(OP_READ, rnd_len(), rnd64());
              2:       add_req(OP_PEEK, rnd_len(), rnd64());
              default: add_req(OP_SKIP, rnd_len(), rnd64());
            endcase
          end
        end
        3, 4: begin
          add_req(OP_BEGIN, rnd_len(), rnd64());
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) begin
            add_req(OP_AMEND, rnd_len(), rnd64());
            if ($urandom_range(0, 3) == 0)
              add_req($urandom_range(0, 1) ? OP_WRITE : OP_READ, rnd_len(), rnd64());
          end
          if ($urandom_range(0, 7) != 0) add_req(OP_COMMIT, rnd_len(), rnd64());
        end
        5: begin
          // Fill until the ring refuses, then top up with short writes.
          for (k = 0; k < 130; k++) add_req(OP_WRITE, RING_LANES, rnd64());
          for (k = 0; k < 10; k++) add_req(OP_WRITE, $urandom_range(1, 8), rnd64());
        end
        6: begin
          for (k = 0; k < 140; k++)
            add_req($urandom_range(0, 1) ? OP_READ : OP_SKIP,
                    $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : RING_LANES,
                    rnd64());
        end
        7: begin
          add_req(OP_BEGIN, 0, rnd64());
          for (k = 0; k < 130; k++)
            add_req(OP_AMEND, k < 120 ? RING_LANES : $urandom_range(1, 8), rnd64());
          add_req(OP_COMMIT, 0, rnd64());
        end
        8: begin
          n = $urandom_range(4, 12);
          for (k = 0; k < n; k++)
            add_req(op_e'($urandom_range(0, 7)), $urandom_range(0, 15), rnd64());
        end
        default: begin
          add_req(OP_RESET, rnd_len(), rnd64());
          if ($urandom_range(0, 1)) add_req(OP_COMMIT, 0, rnd64());
        end
      endcase
    end
    total_reqs = req_q.size();

    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (taken_count < total_reqs) @(posedge clk_i);
    while (ring_expect_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d results for %0d requests; %0d were refused or short of space.",
             result_count, taken_count, short_count);
    $display("The ring was left with no free space after %0d requests.", full_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
